FILE: hdl/frame_reassembly_nack_tracker_top_assert.svh
// Assertion macros shared by the checker files.
`ifndef FRAME_REASSEMBLY_NACK_TRACKER_TOP_ASSERT_SVH
`define FRAME_REASSEMBLY_NACK_TRACKER_TOP_ASSERT_SVH
// Same-cycle implication under synchronous active-low reset.
`define FRT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frt assertion failed");
// Next-cycle implication under synchronous active-low reset.
`define FRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frt assertion failed");
`endif

FILE: hdl/frt_pkg.sv
// ----------------------------------------------------------------------------
// frt_pkg
// Shared constants, state type and control bundles of the NACK tracker.
// ----------------------------------------------------------------------------
package frt_pkg;

  localparam int MAX_SLOTS_DEF  = 32;
  localparam int MAX_FRAMES_DEF = 64;

  localparam int SEQ_W   = 32;
  localparam int PPF_W   = 6;
  localparam int LIMIT_W = 7;
  localparam int CFG_W   = 7;

  localparam logic [PPF_W-1:0]   PPF_RST   = 6'd32;
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 7'd40;

  localparam logic REG_PPF   = 1'b0;
  localparam logic REG_LIMIT = 1'b1;

  localparam logic KIND_REQUEST = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SWEEP,
    ST_WR1,
    ST_WR2,
    ST_CONS,
    ST_WALK,
    ST_FIN
  } frt_state_t;

  typedef struct packed {
    logic load;
    logic cnt_clr;
    logic cnt_inc;
    logic div_step;
    logic sweep_step;
    logic wr1;
    logic wr2;
    logic cons;
    logic walk_step;
    logic fin;
  } frt_cmd_t;

  typedef struct packed {
    logic div_done;
    logic sweep_done;
    logic walk_done;
    logic do_send;
  } frt_status_t;

endpackage

FILE: hdl/frt_ram.sv
// ----------------------------------------------------------------------------
// frt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module frt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

FILE: hdl/frt_ctrl.sv
// ----------------------------------------------------------------------------
// frt_ctrl
// Sequencer: divide, table sweep, table updates, request walk, final beat.
// ----------------------------------------------------------------------------
module frt_ctrl import frt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  frt_status_t status,
  output logic        busy,
  output frt_cmd_t    cmd
);

  frt_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (start) state_nxt = ST_DIV;
      ST_DIV:   if (status.div_done) state_nxt = ST_SWEEP;
      ST_SWEEP: if (status.sweep_done) state_nxt = ST_WR1;
      ST_WR1:   state_nxt = ST_WR2;
      ST_WR2:   state_nxt = ST_CONS;
      ST_CONS:  state_nxt = status.do_send ? ST_WALK : ST_FIN;
      ST_WALK:  if (status.walk_done) state_nxt = ST_FIN;
      ST_FIN:   state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cmd.cnt_inc  = 1'b1;
        cmd.cnt_clr  = status.div_done;
      end
      ST_SWEEP: begin
        cmd.sweep_step = 1'b1;
        cmd.cnt_inc    = 1'b1;
      end
      ST_WR1:  cmd.wr1 = 1'b1;
      ST_WR2:  cmd.wr2 = 1'b1;
      ST_CONS: begin
        cmd.cons    = 1'b1;
        cmd.cnt_clr = 1'b1;
      end
      ST_WALK: begin
        cmd.walk_step = 1'b1;
        cmd.cnt_inc   = 1'b1;
      end
      ST_FIN:  cmd.fin = 1'b1;
      default: cmd = '0;
    endcase
  end

endmodule

FILE: hdl/frt_dpath.sv
// ----------------------------------------------------------------------------
// frt_dpath
// Datapath: config registers, divider, frame table, pointers, result register.
// ----------------------------------------------------------------------------
module frt_dpath import frt_pkg::*; #(
  parameter int MAX_SLOTS  = MAX_SLOTS_DEF,
  parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [CFG_W-1:0]   cfg_wdata,
  input  logic [SEQ_W-1:0]   in_seq_number,
  input  frt_cmd_t           cmd,
  output frt_status_t        status,
  output logic               out_strobe,
  output logic               out_kind,
  output logic [SEQ_W-1:0]   out_requested_seq,
  output logic [SEQ_W-1:0]   out_frame_number,
  output logic               out_dropped,
  output logic               out_consumed,
  output logic               out_overflow,
  output logic               out_last
);

  localparam int SW   = $clog2(MAX_SLOTS + 1);
  localparam int SIW  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int IW   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int FW   = $clog2(MAX_FRAMES + 1);
  localparam int CNTW = (FW > 6) ? FW : 6;
  localparam int RW   = SEQ_W + 2 * MAX_SLOTS;

  // config
  logic [PPF_W-1:0]   ppf_cfg_r;
  logic [LIMIT_W-1:0] limit_r;
  logic [SW-1:0]      ppf_eff;

  // per-packet work registers
  logic [SW-1:0]        ppf_r;
  logic [SEQ_W-1:0]     quo_r;
  logic [SW-1:0]        rem_r;
  logic [CNTW-1:0]      cnt_r;
  logic [SEQ_W-1:0]     sp_r, cp_r;
  logic [FW-1:0]        count_r;
  logic [MAX_FRAMES-1:0] valid_r;

  logic [IW-1:0]        rd_idx_r;
  logic                 rd_vld_r;
  logic                 hit_f_r, hit_s_r, hit_c_r;
  logic [IW-1:0]        idx_f_r, idx_s_r, idx_c_r;
  logic [RW-1:0]        row_f_r, row_s_r;
  logic [MAX_SLOTS-1:0] req_c_r;
  logic                 fr1_ok_r, fr2_ok_r, used_fr1_r;
  logic [IW-1:0]        fr1_r, fr2_r;
  logic                 dropped_r, ovf_r, consumed_r, do_send_r;
  logic                 s_ex_r;
  logic [IW-1:0]        s_idx_r;
  logic [MAX_SLOTS-1:0] req_new_r, miss_r;
  logic [SEQ_W-1:0]     base_r;

  // RAM
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [RW-1:0] ram_wdata;
  logic [RW-1:0] ram_rdata;

  // combinational helpers
  logic [SW:0]          div_tmp;
  logic [MAX_SLOTS-1:0] mask, bit_v;
  logic [SEQ_W-1:0]     rd_frame;
  logic                 rd_valid;
  logic [MAX_SLOTS-1:0] rcv_f, req_f, rcv_s, req_s, miss_s;
  logic [IW-1:0]        forced_idx;
  logic                 forced_ok;
  logic                 limit_hit;
  logic                 c_ex;
  logic [IW-1:0]        c_idx;
  logic [MAX_SLOTS-1:0] c_req;
  logic                 c_rel;

  always_comb begin
    if (ppf_cfg_r == '0) begin
      ppf_eff = SW'(1);
    end else if (32'(ppf_cfg_r) > 32'(MAX_SLOTS)) begin
      ppf_eff = SW'(MAX_SLOTS);
    end else begin
      ppf_eff = SW'(ppf_cfg_r);
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_SLOTS; i++) begin
      mask[i]  = 32'(i) < 32'(ppf_r);
      bit_v[i] = 32'(i) == 32'(rem_r);
    end
  end

  assign div_tmp  = {rem_r, quo_r[SEQ_W-1]};
  assign rd_frame = ram_rdata[RW-1 -: SEQ_W];
  assign rd_valid = valid_r[rd_idx_r];

  assign rcv_f  = row_f_r[MAX_SLOTS-1:0];
  assign req_f  = row_f_r[2*MAX_SLOTS-1:MAX_SLOTS];
  assign rcv_s  = hit_s_r ? row_s_r[MAX_SLOTS-1:0] : '0;
  assign req_s  = hit_s_r ? row_s_r[2*MAX_SLOTS-1:MAX_SLOTS] : '0;
  assign miss_s = ~(rcv_s | req_s) & mask;

  assign limit_hit  = 32'(count_r) >= 32'(limit_r);
  assign forced_ok  = used_fr1_r ? fr2_ok_r : fr1_ok_r;
  assign forced_idx = used_fr1_r ? fr2_r : fr1_r;

  always_comb begin
    if (do_send_r && (cp_r == sp_r)) begin
      c_ex  = s_ex_r;
      c_idx = s_idx_r;
      c_req = req_new_r;
    end else begin
      c_ex  = hit_c_r;
      c_idx = idx_c_r;
      c_req = req_c_r;
    end
    c_rel = !c_ex || ((c_req & mask) == '0);
  end

  // table writes: frame row in WR1, send row in WR2
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = fr1_r;
    ram_wdata = '0;
    if (cmd.wr1) begin
      if (hit_f_r) begin
        ram_we    = 1'b1;
        ram_waddr = idx_f_r;
        ram_wdata = {quo_r, req_f & ~bit_v, rcv_f | bit_v};
      end else if (!limit_hit && fr1_ok_r) begin
        ram_we    = 1'b1;
        ram_waddr = fr1_r;
        ram_wdata = {quo_r, {MAX_SLOTS{1'b0}}, bit_v};
      end
    end else if (cmd.wr2 && (quo_r > sp_r)) begin
      ram_wdata = {sp_r, req_s | miss_s, rcv_s};
      if (hit_s_r) begin
        ram_we    = 1'b1;
        ram_waddr = idx_s_r;
      end else if (forced_ok) begin
        ram_we    = 1'b1;
        ram_waddr = forced_idx;
      end
    end
  end

  frt_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_FRAMES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cnt_r[IW-1:0]),
    .rdata (ram_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ppf_cfg_r  <= PPF_RST;
      limit_r    <= LIMIT_RST;
      sp_r       <= '0;
      cp_r       <= '0;
      count_r    <= '0;
      valid_r    <= '0;
      cnt_r      <= '0;
      rd_vld_r   <= 1'b0;
      out_strobe <= 1'b0;
    end else begin
      // strobe a request beat for each missing slot, and the status beat
      out_strobe <= cmd.fin || (cmd.walk_step && miss_r[cnt_r[SIW-1:0]]);
      if (cfg_we) begin
        if (cfg_index == REG_PPF) begin
          ppf_cfg_r <= cfg_wdata[PPF_W-1:0];
        end else begin
          limit_r <= cfg_wdata[LIMIT_W-1:0];
        end
      end
      if (cmd.load || cmd.cnt_clr) begin
        cnt_r <= '0;
      end else if (cmd.cnt_inc) begin
        cnt_r <= cnt_r + CNTW'(1);
      end
      if (cmd.load) begin
        rd_vld_r <= 1'b0;
      end else if (cmd.sweep_step) begin
        rd_vld_r <= cnt_r < CNTW'(MAX_FRAMES);
      end
      if (cmd.wr1 && !hit_f_r && !limit_hit && fr1_ok_r) begin
        valid_r[fr1_r] <= 1'b1;
        count_r        <= count_r + FW'(1);
      end
      if (cmd.wr2 && (quo_r > sp_r) && !hit_s_r && forced_ok) begin
        valid_r[forced_idx] <= 1'b1;
        count_r             <= count_r + FW'(1);
      end
      if (cmd.cons && (quo_r > cp_r) && c_rel) begin
        cp_r <= cp_r + SEQ_W'(1);
        if (c_ex) begin
          valid_r[c_idx] <= 1'b0;
          if (count_r != '0) begin
            count_r <= count_r - FW'(1);
          end
        end
      end
      if (cmd.fin && do_send_r) begin
        sp_r <= sp_r + SEQ_W'(1);
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ppf_r      <= ppf_eff;
      quo_r      <= in_seq_number;
      rem_r      <= '0;
      hit_f_r    <= 1'b0;
      hit_s_r    <= 1'b0;
      hit_c_r    <= 1'b0;
      fr1_ok_r   <= 1'b0;
      fr2_ok_r   <= 1'b0;
      used_fr1_r <= 1'b0;
      dropped_r  <= 1'b0;
      ovf_r      <= 1'b0;
      consumed_r <= 1'b0;
      do_send_r  <= 1'b0;
      s_ex_r     <= 1'b0;
    end
    if (cmd.div_step) begin
      if (div_tmp >= {1'b0, ppf_r}) begin
        rem_r <= SW'(div_tmp - {1'b0, ppf_r});
        quo_r <= {quo_r[SEQ_W-2:0], 1'b1};
      end else begin
        rem_r <= div_tmp[SW-1:0];
        quo_r <= {quo_r[SEQ_W-2:0], 1'b0};
      end
    end
    if (cmd.sweep_step) begin
      rd_idx_r <= cnt_r[IW-1:0];
      if (rd_vld_r) begin
        if (rd_valid) begin
          if (rd_frame == quo_r) begin
            hit_f_r <= 1'b1;
            idx_f_r <= rd_idx_r;
            row_f_r <= ram_rdata;
          end
          if (rd_frame == sp_r) begin
            hit_s_r <= 1'b1;
            idx_s_r <= rd_idx_r;
            row_s_r <= ram_rdata;
          end
          if (rd_frame == cp_r) begin
            hit_c_r <= 1'b1;
            idx_c_r <= rd_idx_r;
            req_c_r <= ram_rdata[2*MAX_SLOTS-1:MAX_SLOTS];
          end
        end else if (!fr1_ok_r) begin
          fr1_ok_r <= 1'b1;
          fr1_r    <= rd_idx_r;
        end else if (!fr2_ok_r) begin
          fr2_ok_r <= 1'b1;
          fr2_r    <= rd_idx_r;
        end
      end
    end
    if (cmd.wr1 && !hit_f_r) begin
      if (limit_hit || !fr1_ok_r) begin
        dropped_r <= 1'b1;
      end else begin
        used_fr1_r <= 1'b1;
      end
    end
    if (cmd.wr2) begin
      base_r    <= SEQ_W'(ppf_r * sp_r);
      do_send_r <= quo_r > sp_r;
      req_new_r <= req_s | miss_s;
      miss_r    <= (quo_r > sp_r) ? miss_s : '0;
      s_idx_r   <= hit_s_r ? idx_s_r : forced_idx;
      s_ex_r    <= hit_s_r || forced_ok;
      if ((quo_r > sp_r) && !hit_s_r && !forced_ok) begin
        ovf_r <= 1'b1;
      end
    end
    if (cmd.cons) begin
      consumed_r <= (quo_r > cp_r) && c_rel;
    end
    if (cmd.walk_step) begin
      out_kind          <= KIND_REQUEST;
      out_requested_seq <= base_r + SEQ_W'(cnt_r);
      out_frame_number  <= quo_r;
      out_dropped       <= 1'b0;
      out_consumed      <= 1'b0;
      out_overflow      <= 1'b0;
      out_last          <= 1'b0;
    end
    if (cmd.fin) begin
      out_kind          <= KIND_STATUS;
      out_requested_seq <= '0;
      out_frame_number  <= quo_r;
      out_dropped       <= dropped_r;
      out_consumed      <= consumed_r;
      out_overflow      <= ovf_r;
      out_last          <= 1'b1;
    end
  end

  assign status.div_done   = cnt_r == CNTW'(SEQ_W - 1);
  assign status.sweep_done = cnt_r == CNTW'(MAX_FRAMES);
  assign status.walk_done  = cnt_r == CNTW'(ppf_r) - CNTW'(1);
  assign status.do_send    = do_send_r;

endmodule

FILE: hdl/frame_reassembly_nack_tracker_top.sv
// ----------------------------------------------------------------------------
// frame_reassembly_nack_tracker_top
// NACK-based selective-repeat receiver: frame table and retransmit requests.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive in_seq_number and pulse start while busy is low; that beat
//   is taken. busy stays high until the packet's work is done.
//   Output: each result beat shows for one cycle with out_strobe high. A
//   packet gives zero or more request beats (out_kind low, slot order) and
//   then one status beat (out_kind high, out_last high). The receiver has no
//   way to stall; results must be taken as they appear.
//   Config: cfg_we with cfg_index 0 writes packets_per_frame, index 1 writes
//   frame_limit. Write only while busy is low.
// Timing:
//   One packet passes the bit-serial divider, then one pass through the frame
//   table RAM (one row a cycle), the update states WR1, WR2 and CONS, the
//   request walk (one slot a cycle, only when the send pointer advances, over
//   the effective packets_per_frame slots) and the status beat. The status
//   beat appears in the same cycle that busy falls; the next start may be
//   given in that same cycle.
// Reset: synchronous; clears pointers, entry count, valid bits and config to
//   32 packets per frame and a frame limit of 40. No RAM clearing pass.
// ----------------------------------------------------------------------------
module frame_reassembly_nack_tracker_top import frt_pkg::*; #(
  parameter int MAX_SLOTS  = MAX_SLOTS_DEF,
  parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             start,
  output logic             busy,
  input  logic [SEQ_W-1:0] in_seq_number,
  output logic             out_strobe,
  output logic             out_kind,
  output logic [SEQ_W-1:0] out_requested_seq,
  output logic [SEQ_W-1:0] out_frame_number,
  output logic             out_dropped,
  output logic             out_consumed,
  output logic             out_overflow,
  output logic             out_last
);

  // command and status between sequencer and datapath
  frt_cmd_t    cmd;
  frt_status_t status;

  frt_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  frt_dpath #(
    .MAX_SLOTS  (MAX_SLOTS),
    .MAX_FRAMES (MAX_FRAMES)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_seq_number     (in_seq_number),
    .cmd               (cmd),
    .status            (status),
    .out_strobe        (out_strobe),
    .out_kind          (out_kind),
    .out_requested_seq (out_requested_seq),
    .out_frame_number  (out_frame_number),
    .out_dropped       (out_dropped),
    .out_consumed      (out_consumed),
    .out_overflow      (out_overflow),
    .out_last          (out_last)
  );

endmodule

FILE: hdl/frt_checker.sv
// ----------------------------------------------------------------------------
// frt_checker
// Port-level checks of the tracker's beat sequence, bound to the top level.
// ----------------------------------------------------------------------------
`include "frame_reassembly_nack_tracker_top_assert.svh"

module frt_checker import frt_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input logic             out_strobe,
  input logic             out_kind,
  input logic [SEQ_W-1:0] out_requested_seq,
  input logic             out_dropped,
  input logic             out_consumed,
  input logic             out_overflow,
  input logic             out_last
);

  logic req_clean;
  logic status_form;

  assign req_clean   = !out_last && !out_dropped && !out_consumed && !out_overflow;
  assign status_form = out_last && (out_requested_seq == '0);

  `FRT_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
  `FRT_ASSERT_IMPL(a_end_status, clk, rst_n, $fell(busy) && $past(rst_n), out_strobe && out_last)
  `FRT_ASSERT_NEXT(a_last_gap, clk, rst_n, out_strobe && out_last, !out_strobe)
  `FRT_ASSERT_IMPL(a_req_clean, clk, rst_n, out_strobe && !out_kind, req_clean)
  `FRT_ASSERT_IMPL(a_status_form, clk, rst_n, out_strobe && out_kind, status_form)

endmodule

bind frame_reassembly_nack_tracker_top frt_checker u_frt_checker (.*);
